// ===== hdl/ffca_pkg.sv =====
// shared types and codes for the first-fit chunk allocator
package ffca_pkg;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_NO_FIT    = 3'd1,
    ST_APPENDED  = 3'd2,
    ST_FULL      = 3'd3,
    ST_MISALIGN  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APP_CHK,
    S_APP_POP,
    S_APP_WR,
    S_APP_LINK,
    S_ALC_CHK,
    S_ALC_CMP,
    S_RESP
  } fsm_t;

  localparam logic CMD_APPEND   = 1'b0;
  localparam logic CMD_ALLOCATE = 1'b1;

  localparam int unsigned ALIGN_W = 4;
  localparam int unsigned AMASK_W = 16;
  localparam int unsigned WANT_W  = 34;
  localparam logic [ALIGN_W-1:0] ALIGN_RESET = 4'd3;

endpackage

// ===== hdl/first_fit_chunk_allocator_top.sv =====
// first-fit free chunk allocator: linked chunk table walked by a small sequencer
//
// Keeps an ordered list of free chunks (start, size) in a table of MAX_CHUNKS slots,
// linked through a next-pointer memory. A word with cmd 0 appends a chunk at the tail
// (status 2), unless its size is not a multiple of 2^align_log2 (status 4) or every slot
// is taken (status 3). A word with cmd 1 rounds request_size up to the alignment and walks
// from the head for the first chunk at least that big: a larger chunk gives away a block
// cut from its end, an exact fit is unlinked and returned whole, otherwise status 1.
// One word is in flight at a time; in_stall is high from acceptance until the result is
// loaded into the output register, which may still be waiting on out_stall while the next
// word is taken. An allocate walks the list from the head: the single read port of the
// chunk table is read once per visited chunk, and the compare and subtract unit checks one
// chunk per cycle. Freed slots go onto a stack and never-used slots come from a fill count,
// so no clearing pass is needed after reset. align_log2 is written through cfg_wen/cfg_wdata;
// the user must do so only while idle, as the block itself does not enforce it.
module first_fit_chunk_allocator_top #(
  parameter int unsigned MAX_CHUNKS = 64,
  parameter int unsigned ADDR_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wen,
  input  logic [3:0]  cfg_wdata,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [31:0] chunk_start,
  input  logic [31:0] chunk_size,
  input  logic [31:0] request_size,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] block_start,
  output logic [31:0] block_size
);
  import ffca_pkg::*;

  localparam int unsigned IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int unsigned PTR_W = $clog2(MAX_CHUNKS + 1);
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(MAX_CHUNKS);

  // chunk table and free slot stack
  logic [ADDR_BITS-1:0] entry_start [MAX_CHUNKS];
  logic [ADDR_BITS-1:0] entry_size  [MAX_CHUNKS];
  logic [PTR_W-1:0]     entry_next  [MAX_CHUNKS];
  logic [PTR_W-1:0]     free_stack  [MAX_CHUNKS];

  fsm_t state, state_next;

  logic [ALIGN_W-1:0]   align_log2;
  logic [31:0]          start_q, size_q, request_q;
  logic [ADDR_BITS-1:0] want;
  logic [PTR_W-1:0]     slot, cur, prev, head, tail, fill, free_top;
  status_t              pend_status;
  logic [31:0]          pend_start, pend_size;

  // registered read data
  logic [ADDR_BITS-1:0] rd_start, rd_size;
  logic [PTR_W-1:0]     rd_next, fs_rdata;

  // memory controls
  logic                 rd_en, fs_rd_en;
  logic [IDX_W-1:0]     rd_addr, fs_raddr;
  logic                 st_we, sz_we, nx_we, fs_we;
  logic [IDX_W-1:0]     st_waddr, sz_waddr, nx_waddr, fs_waddr;
  logic [ADDR_BITS-1:0] st_wdata, sz_wdata;
  logic [PTR_W-1:0]     nx_wdata, fs_wdata;

  // shared arithmetic
  logic [AMASK_W-1:0]   amask;
  logic                 misaligned;
  logic [WANT_W-1:0]    want_round;
  logic [64:0]          want_wide, addr_max;
  logic                 want_over;
  logic                 fits;
  logic [ADDR_BITS-1:0] rest, cut_start;
  logic [63:0]          in_start64, in_size64, cut64, want64, rd_start64, rd_size64;

  assign amask      = AMASK_W'((17'd1 << align_log2) - 17'd1);
  assign misaligned = |(size_q & 32'(amask));
  assign want_round = (WANT_W'(request_q) + WANT_W'(amask)) & ~WANT_W'(amask);
  assign want_wide  = 65'(want_round);
  assign addr_max   = (65'd1 << ADDR_BITS) - 65'd1;
  assign want_over  = want_wide > addr_max;
  assign fits       = rd_size >= want;
  assign rest       = rd_size - want;
  assign cut_start  = rd_start + rest;
  assign in_start64 = 64'(start_q);
  assign in_size64  = 64'(size_q);
  assign cut64      = 64'(cut_start);
  assign want64     = 64'(want);
  assign rd_start64 = 64'(rd_start);
  assign rd_size64  = 64'(rd_size);

  assign in_stall = (state != S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (cmd == CMD_ALLOCATE) ? S_ALC_CHK : S_APP_CHK;
        end
      end
      S_APP_CHK: begin
        if (misaligned) begin
          state_next = S_RESP;
        end else if (free_top != '0) begin
          state_next = S_APP_POP;
        end else if (fill != NULL_PTR) begin
          state_next = S_APP_WR;
        end else begin
          state_next = S_RESP;
        end
      end
      S_APP_POP:  state_next = S_APP_WR;
      S_APP_WR:   state_next = (tail != NULL_PTR) ? S_APP_LINK : S_RESP;
      S_APP_LINK: state_next = S_RESP;
      S_ALC_CHK: begin
        state_next = (want_over || head == NULL_PTR) ? S_RESP : S_ALC_CMP;
      end
      S_ALC_CMP: begin
        if (fits || rd_next == NULL_PTR) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = cur[IDX_W-1:0];
    fs_rd_en = 1'b0;
    fs_raddr = IDX_W'(free_top - 1'b1);
    st_we    = 1'b0;
    st_waddr = slot[IDX_W-1:0];
    st_wdata = in_start64[ADDR_BITS-1:0];
    sz_we    = 1'b0;
    sz_waddr = slot[IDX_W-1:0];
    sz_wdata = in_size64[ADDR_BITS-1:0];
    nx_we    = 1'b0;
    nx_waddr = slot[IDX_W-1:0];
    nx_wdata = NULL_PTR;
    fs_we    = 1'b0;
    fs_waddr = free_top[IDX_W-1:0];
    fs_wdata = cur;
    unique case (state)
      S_APP_CHK: begin
        fs_rd_en = !misaligned && (free_top != '0);
      end
      S_APP_WR: begin
        st_we = 1'b1;
        sz_we = 1'b1;
        nx_we = 1'b1;
      end
      S_APP_LINK: begin
        nx_we    = 1'b1;
        nx_waddr = tail[IDX_W-1:0];
        nx_wdata = slot;
      end
      S_ALC_CHK: begin
        rd_en   = !want_over && (head != NULL_PTR);
        rd_addr = head[IDX_W-1:0];
      end
      S_ALC_CMP: begin
        if (fits && rest != '0) begin
          sz_we    = 1'b1;
          sz_waddr = cur[IDX_W-1:0];
          sz_wdata = rest;
        end else if (fits) begin
          nx_we    = (prev != NULL_PTR);
          nx_waddr = prev[IDX_W-1:0];
          nx_wdata = rd_next;
          fs_we    = 1'b1;
        end else begin
          rd_en   = (rd_next != NULL_PTR);
          rd_addr = rd_next[IDX_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (st_we) entry_start[st_waddr] <= st_wdata;
    if (sz_we) entry_size[sz_waddr] <= sz_wdata;
    if (nx_we) entry_next[nx_waddr] <= nx_wdata;
    if (fs_we) free_stack[fs_waddr] <= fs_wdata;
    if (rd_en) begin
      rd_start <= entry_start[rd_addr];
      rd_size  <= entry_size[rd_addr];
      rd_next  <= entry_next[rd_addr];
    end
    if (fs_rd_en) fs_rdata <= free_stack[fs_raddr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        start_q   <= chunk_start;
        size_q    <= chunk_size;
        request_q <= request_size;
      end
      S_APP_CHK: begin
        slot        <= fill;
        pend_status <= misaligned ? ST_MISALIGN : ST_FULL;
        pend_start  <= '0;
        pend_size   <= '0;
      end
      S_APP_POP: slot <= fs_rdata;
      S_APP_WR, S_APP_LINK: pend_status <= ST_APPENDED;
      S_ALC_CHK: begin
        want        <= want_wide[ADDR_BITS-1:0];
        cur         <= head;
        prev        <= NULL_PTR;
        pend_status <= ST_NO_FIT;
        pend_start  <= '0;
        pend_size   <= '0;
      end
      S_ALC_CMP: begin
        if (fits && rest != '0) begin
          pend_status <= ST_ALLOCATED;
          pend_start  <= cut64[31:0];
          pend_size   <= want64[31:0];
        end else if (fits) begin
          pend_status <= ST_ALLOCATED;
          pend_start  <= rd_start64[31:0];
          pend_size   <= rd_size64[31:0];
        end else begin
          prev <= cur;
          cur  <= rd_next;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      align_log2  <= ALIGN_RESET;
      head        <= NULL_PTR;
      tail        <= NULL_PTR;
      fill        <= '0;
      free_top    <= '0;
      out_valid   <= 1'b0;
      status      <= 3'(ST_NO_FIT);
      block_start <= '0;
      block_size  <= '0;
    end else begin
      state <= state_next;
      if (cfg_wen) align_log2 <= cfg_wdata;
      // result register: load a new word or drop the one taken
      if (state == S_RESP && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_APP_CHK: begin
          if (!misaligned && free_top == '0 && fill != NULL_PTR) begin
            fill <= fill + 1'b1;
          end
        end
        S_APP_POP: free_top <= free_top - 1'b1;
        S_APP_WR: begin
          if (tail == NULL_PTR) begin
            head <= slot;
            tail <= slot;
          end
        end
        S_APP_LINK: tail <= slot;
        S_ALC_CMP: begin
          if (fits && rest == '0) begin
            if (prev == NULL_PTR) head <= rd_next;
            if (tail == cur) tail <= prev;
            free_top <= free_top + 1'b1;
          end
        end
        S_RESP: begin
          if (!out_valid || !out_stall) begin
            status      <= 3'(pend_status);
            block_start <= pend_start;
            block_size  <= pend_size;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
